// File: hw/rtl/mm_pkg.sv
`default_nettype none

package mm_pkg;

	// array geometry
	localparam int MAX_DIM     = 4;
	localparam int DIM_LIMIT   = (MAX_DIM < 4) ? MAX_DIM : 4;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	// field widths
	localparam int IDX_W  = 2;
	localparam int DIM_W  = 3;
	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int SUM_W  = 34;

	// configuration port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		REQ_LOAD_A  = 2'd0,
		REQ_LOAD_B  = 2'd1,
		REQ_COMPUTE = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		REG_A_ROWS     = 2'd0,
		REG_INNER_SIZE = 2'd1,
		REG_B_COLS     = 2'd2
	} reg_idx_t;

	// dimensions after clamping to 1..DIM_LIMIT
	typedef struct packed {
		logic [DIM_W-1:0] a_rows;
		logic [DIM_W-1:0] inner_size;
		logic [DIM_W-1:0] b_cols;
	} dims_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(DIM_LIMIT)) begin
			r = DIM_W'(DIM_LIMIT);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// row-major store address
	function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM)) + ADDR_W'(col);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mm_req_if.sv
`default_nettype none

interface mm_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 req_type;
	logic [mm_pkg::IDX_W-1:0]   row_index;
	logic [mm_pkg::IDX_W-1:0]   col_index;
	logic signed [mm_pkg::ELEM_W-1:0] element_value;

	modport source (output valid, output req_type, output row_index, output col_index,
		output element_value, input ready);
	modport sink (input valid, input req_type, input row_index, input col_index,
		input element_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mm_res_if.sv
`default_nettype none

interface mm_res_if;
	logic                            valid;
	logic                            ready;
	logic [mm_pkg::IDX_W-1:0]        out_row;
	logic [mm_pkg::IDX_W-1:0]        out_col;
	logic signed [mm_pkg::SUM_W-1:0] product_value;
	logic                            last;

	modport source (output valid, output out_row, output out_col, output product_value,
		output last, input ready);
	modport sink (input valid, input out_row, input out_col, input product_value,
		input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mm_regs.sv
`default_nettype none

module mm_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mm_pkg::APB_AW-1:0]   paddr,
	input  wire logic [mm_pkg::APB_DW-1:0]   pwdata,
	output logic      [mm_pkg::APB_DW-1:0]   prdata,
	output logic                             pready,
	output mm_pkg::dims_t                    dims
);

	logic [mm_pkg::DIM_W-1:0] a_rows_q;
	logic [mm_pkg::DIM_W-1:0] inner_size_q;
	logic [mm_pkg::DIM_W-1:0] b_cols_q;
	logic                     wr_en;
	logic [1:0]               reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[3:2];

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q     <= mm_pkg::DIM_W'(4);
			inner_size_q <= mm_pkg::DIM_W'(4);
			b_cols_q     <= mm_pkg::DIM_W'(4);
		end else if (wr_en) begin
			unique case (reg_sel)
				mm_pkg::REG_A_ROWS:     a_rows_q     <= pwdata[mm_pkg::DIM_W-1:0];
				mm_pkg::REG_INNER_SIZE: inner_size_q <= pwdata[mm_pkg::DIM_W-1:0];
				mm_pkg::REG_B_COLS:     b_cols_q     <= pwdata[mm_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_sel)
			mm_pkg::REG_A_ROWS:     prdata = mm_pkg::APB_DW'(a_rows_q);
			mm_pkg::REG_INNER_SIZE: prdata = mm_pkg::APB_DW'(inner_size_q);
			mm_pkg::REG_B_COLS:     prdata = mm_pkg::APB_DW'(b_cols_q);
			default:                prdata = '0;
		endcase
	end

	// dimensions as the sequencer uses them
	assign dims.a_rows     = mm_pkg::clamp_dim(a_rows_q);
	assign dims.inner_size = mm_pkg::clamp_dim(inner_size_q);
	assign dims.b_cols     = mm_pkg::clamp_dim(b_cols_q);

endmodule

`default_nettype wire

// File: hw/rtl/matrix_multiply.sv
// Dense matrix product C = A x B on two 16-entry element memories. A load
// request (A or B) is accepted while idle and writes one Q8.8 element; a
// compute request then streams every element of C row by row with last on
// the final one. One multiply-accumulate unit walks the inner dimension, so
// each output element needs inner_size memory reads, then the multiply and
// the final add into the output register, plus any wait while the output
// register holds its previous transfer. No new request is taken until the
// final element sits in the output register. Dimension registers are
// clamped to 1..4 and must be written while idle.
`default_nettype none

module matrix_multiply (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	mm_req_if.sink                         req,
	mm_res_if.source                       res,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [mm_pkg::APB_AW-1:0] paddr,
	input  wire logic [mm_pkg::APB_DW-1:0] pwdata,
	output logic      [mm_pkg::APB_DW-1:0] prdata,
	output logic                           pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_WAIT
	} st_t;

	mm_pkg::dims_t dims;

	st_t                                state_q;
	logic [mm_pkg::IDX_W-1:0]           i_q;
	logic [mm_pkg::IDX_W-1:0]           j_q;
	logic [mm_pkg::IDX_W-1:0]           k_q;

	logic signed [mm_pkg::ELEM_W-1:0]   a_mem [mm_pkg::STORE_DEPTH];
	logic signed [mm_pkg::ELEM_W-1:0]   b_mem [mm_pkg::STORE_DEPTH];
	logic signed [mm_pkg::ELEM_W-1:0]   a_rd_s1;
	logic signed [mm_pkg::ELEM_W-1:0]   b_rd_s1;
	logic                               vld_s1;
	logic                               first_s1;
	logic                               lastk_s1;
	logic signed [mm_pkg::PROD_W-1:0]   prod_s2;
	logic                               vld_s2;
	logic                               first_s2;
	logic                               lastk_s2;
	logic signed [mm_pkg::SUM_W-1:0]    acc_q;

	logic                               out_valid_q;
	logic [mm_pkg::IDX_W-1:0]           out_row_q;
	logic [mm_pkg::IDX_W-1:0]           out_col_q;
	logic signed [mm_pkg::SUM_W-1:0]    out_value_q;
	logic                               out_last_q;

	logic                               req_fire;
	logic                               load_ok;
	logic                               we_a;
	logic                               we_b;
	logic [mm_pkg::ADDR_W-1:0]          wr_addr;
	logic                               issue;
	logic                               k_end;
	logic                               i_end;
	logic                               j_end;
	logic                               out_free;
	logic                               elem_done;
	logic                               stall;
	logic signed [mm_pkg::SUM_W-1:0]    sum;

	// configuration registers
	mm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dims    (dims)
	);

	// request side: loads and compute start only when idle
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid & req.ready;
	assign load_ok   = (int'(req.row_index) < mm_pkg::DIM_LIMIT) &&
		(int'(req.col_index) < mm_pkg::DIM_LIMIT);
	assign we_a      = req_fire && (req.req_type == mm_pkg::REQ_LOAD_A) && load_ok;
	assign we_b      = req_fire && (req.req_type == mm_pkg::REQ_LOAD_B) && load_ok;
	assign wr_addr   = mm_pkg::store_addr(req.row_index, req.col_index);

	// loop bounds
	assign k_end = (k_q == mm_pkg::IDX_W'(dims.inner_size - 1'b1));
	assign j_end = (j_q == mm_pkg::IDX_W'(dims.b_cols - 1'b1));
	assign i_end = (i_q == mm_pkg::IDX_W'(dims.a_rows - 1'b1));
	assign issue = (state_q == ST_MAC);

	// output register handoff
	assign out_free  = !out_valid_q || res.ready;
	assign elem_done = vld_s2 && lastk_s2 && out_free;
	assign stall     = vld_s2 && lastk_s2 && !out_free;
	assign sum       = (first_s2 ? '0 : acc_q) + mm_pkg::SUM_W'(prod_s2);

	// element memories, registered read
	always_ff @(posedge clk) begin
		if (we_a) begin
			a_mem[wr_addr] <= req.element_value;
		end
		if (we_b) begin
			b_mem[wr_addr] <= req.element_value;
		end
		a_rd_s1 <= a_mem[mm_pkg::store_addr(i_q, k_q)];
		b_rd_s1 <= b_mem[mm_pkg::store_addr(k_q, j_q)];
	end

	// mac pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (!stall) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// mac pipeline datapath
	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		lastk_s1 <= k_end;
		if (!stall) begin
			prod_s2  <= a_rd_s1 * b_rd_s1;
			first_s2 <= first_s1;
			lastk_s2 <= lastk_s1;
		end
		if (vld_s2 && !stall) begin
			acc_q <= sum;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (elem_done) begin
				out_valid_q <= 1'b1;
				out_row_q   <= i_q;
				out_col_q   <= j_q;
				out_value_q <= sum;
				out_last_q  <= i_end && j_end;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && (req.req_type == mm_pkg::REQ_COMPUTE)) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (k_end) begin
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (elem_done) begin
						k_q <= '0;
						if (i_end && j_end) begin
							state_q <= ST_IDLE;
						end else begin
							if (j_end) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
							state_q <= ST_MAC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid         = out_valid_q;
	assign res.out_row       = out_row_q;
	assign res.out_col       = out_col_q;
	assign res.product_value = out_value_q;
	assign res.last          = out_last_q;

`ifndef SYNTH
	// memories are never written while a product is being read out
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !(we_a || we_b))
		else $error("element memory written during compute");

	// one element in flight: its final term is alone in the pipeline
	a_one_elem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && lastk_s2) |-> !vld_s1)
		else $error("next element issued before previous finished");

	// a compute request closes the request side on the next cycle
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (req.req_type == mm_pkg::REQ_COMPUTE)) |=> !req.ready)
		else $error("request accepted right after compute start");

	// inner index stays within the configured inner size
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (mm_pkg::DIM_W'(k_q) < dims.inner_size))
		else $error("inner index out of range");
`endif

endmodule

`default_nettype wire

// File: tb/sv/matrix_multiply_tb.sv
`timescale 1ns / 100ps

module matrix_multiply_tb;
	import mm_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 56;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [ELEM_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [SUM_W-1:0] value;
		logic                    last;
	} prod_elem_t;

	typedef struct packed {
		req_item_t        item;
		logic             typed;
		logic [SUM_W-1:0] want;
	} step_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	mm_req_if req_ch();
	mm_res_if res_ch();

	matrix_multiply dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// model state of the block
	logic signed [ELEM_W-1:0] a_mem [STORE_DEPTH];
	logic signed [ELEM_W-1:0] b_mem [STORE_DEPTH];
	bit a_set [STORE_DEPTH];
	bit b_set [STORE_DEPTH];
	logic [DIM_W-1:0] rows_reg = 3'd4;
	logic [DIM_W-1:0] inner_reg = 3'd4;
	logic [DIM_W-1:0] cols_reg = 3'd4;

	prod_elem_t pending_elems [$];
	int err_count = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	// directed steps: single-element product, typed results where obvious
	step_t directed_steps [18] = '{
		'{'{REQ_LOAD_A, 2'd0, 2'd0, 16'h7FFF}, 1'b0, 34'd0},
		'{'{REQ_LOAD_B, 2'd0, 2'd0, 16'h8000}, 1'b0, 34'd0},
		'{'{REQ_COMPUTE, 2'd0, 2'd0, 16'h0000}, 1'b1, -34'sd1073709056},
		'{'{REQ_LOAD_A, 2'd0, 2'd0, 16'h8000}, 1'b0, 34'd0},
		'{'{REQ_COMPUTE, 2'd3, 2'd3, 16'hFFFF}, 1'b1, 34'sd1073741824},
		'{'{REQ_UNUSED, 2'd3, 2'd3, 16'hFFFF}, 1'b0, 34'd0},
		'{'{REQ_LOAD_B, 2'd0, 2'd0, 16'h0100}, 1'b0, 34'd0},
		'{'{REQ_COMPUTE, 2'd0, 2'd0, 16'h0000}, 1'b1, -34'sd8388608},
		'{'{REQ_LOAD_A, 2'd3, 2'd3, 16'h7FFF}, 1'b0, 34'd0},
		'{'{REQ_LOAD_B, 2'd3, 2'd3, 16'h8000}, 1'b0, 34'd0},
		'{'{REQ_LOAD_A, 2'd0, 2'd0, 16'h0000}, 1'b0, 34'd0},
		'{'{REQ_COMPUTE, 2'd0, 2'd0, 16'h0000}, 1'b1, 34'd0},
		'{'{REQ_LOAD_A, 2'd0, 2'd0, 16'hFFFF}, 1'b0, 34'd0},
		'{'{REQ_LOAD_B, 2'd0, 2'd0, 16'hFFFF}, 1'b0, 34'd0},
		'{'{REQ_COMPUTE, 2'd0, 2'd0, 16'h0000}, 1'b1, 34'd1},
		'{'{REQ_LOAD_A, 2'd2, 2'd1, 16'h5A5A}, 1'b0, 34'd0},
		'{'{REQ_LOAD_B, 2'd1, 2'd2, 16'hA5A5}, 1'b0, 34'd0},
		'{'{REQ_COMPUTE, 2'd1, 2'd2, 16'h1234}, 1'b0, 34'd0}
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int used_dim(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (v > DIM_LIMIT) begin
			return DIM_LIMIT;
		end
		return int'(v);
	endfunction

	// update stores, or queue every element of the product
	function automatic void predict_request(input req_item_t it, input bit typed,
			input logic [SUM_W-1:0] want);
		int nr;
		int nk;
		int nc;
		int n;
		longint acc;
		prod_elem_t e;
		case (it.kind)
			REQ_LOAD_A: begin
				a_mem[it.row * MAX_DIM + it.col] = it.value;
				a_set[it.row * MAX_DIM + it.col] = 1'b1;
			end
			REQ_LOAD_B: begin
				b_mem[it.row * MAX_DIM + it.col] = it.value;
				b_set[it.row * MAX_DIM + it.col] = 1'b1;
			end
			REQ_COMPUTE: begin
				nr = used_dim(rows_reg);
				nk = used_dim(inner_reg);
				nc = used_dim(cols_reg);
				n = 0;
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						acc = 0;
						for (int k = 0; k < nk; k++) begin
							acc += longint'(a_mem[i * MAX_DIM + k]) * longint'(b_mem[k * MAX_DIM + j]);
						end
						e.row = i[IDX_W-1:0];
						e.col = j[IDX_W-1:0];
						e.value = typed ? want : acc[SUM_W-1:0];
						e.last = (n + 1 == nr * nc);
						pending_elems.push_back(e);
						n++;
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	// first store entry the current product would read before it is loaded
	function automatic bit first_gap(output req_item_t gap);
		int nr;
		int nk;
		int nc;
		nr = used_dim(rows_reg);
		nk = used_dim(inner_reg);
		nc = used_dim(cols_reg);
		gap = '0;
		for (int i = 0; i < nr; i++) begin
			for (int k = 0; k < nk; k++) begin
				if (!a_set[i * MAX_DIM + k]) begin
					gap = '{REQ_LOAD_A, i[IDX_W-1:0], k[IDX_W-1:0], 16'h0000};
					return 1'b1;
				end
			end
		end
		for (int k = 0; k < nk; k++) begin
			for (int j = 0; j < nc; j++) begin
				if (!b_set[k * MAX_DIM + j]) begin
					gap = '{REQ_LOAD_B, k[IDX_W-1:0], j[IDX_W-1:0], 16'h0000};
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [ELEM_W-1:0] pick_value(input bit harsh);
		if (harsh && $urandom_range(1) == 0) begin
			return 16'h8000;
		end
		if (harsh || $urandom_range(3) == 0) begin
			case ($urandom_range(3))
				0: return 16'h7FFF;
				1: return 16'h8000;
				2: return 16'h0000;
				default: return 16'hFFFF;
			endcase
		end
		return ELEM_W'($urandom());
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		err_count++;
	endtask

	// one request transfer, with random idle cycles ahead of it
	task automatic send_req(input req_item_t it, input bit typed, input logic [SUM_W-1:0] want);
		while (!calm && $urandom_range(99) < 21) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.req_type = it.kind;
		req_ch.row_index = it.row;
		req_ch.col_index = it.col;
		req_ch.element_value = it.value;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		predict_request(it, typed, want);
		@(negedge clk);
	endtask

	// register write then read back, each a setup and an access
	task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] dim);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = ($urandom() & ~32'h7) | APB_DW'(dim);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		case (idx)
			REG_A_ROWS: rows_reg = dim;
			REG_INNER_SIZE: inner_reg = dim;
			REG_B_COLS: cols_reg = dim;
			default: begin
			end
		endcase
		@(negedge clk);
		// read back the same register
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (prdata !== APB_DW'(dim)) begin
			report_mismatch($sformatf("register %0d read %0d want %0d", idx, prdata, dim));
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// drain the product stream and let a trailing load finish
	task automatic settle();
		req_ch.valid = 1'b0;
		while (pending_elems.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	// result side: ready with random stalls, one long hold-off
	initial begin
		bit hold_served;
		hold_served = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				res_ch.ready = calm || ($urandom_range(99) >= 21);
			end
		end
	end

	// compare each result transfer with the oldest queued element
	always @(posedge clk) begin
		prod_elem_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_elems.size() == 0) begin
				report_mismatch("result transfer with no element queued");
			end else begin
				e = pending_elems.pop_front();
				if (res_ch.out_row !== e.row) begin
					report_mismatch($sformatf("out_row got %0d want %0d", res_ch.out_row, e.row));
				end
				if (res_ch.out_col !== e.col) begin
					report_mismatch($sformatf("out_col got %0d want %0d", res_ch.out_col, e.col));
				end
				if (res_ch.product_value !== e.value) begin
					report_mismatch($sformatf("product_value at (%0d,%0d) got %0d want %0d",
						e.row, e.col, res_ch.product_value, e.value));
				end
				if (res_ch.last !== e.last) begin
					report_mismatch($sformatf("last at (%0d,%0d) got %0b want %0b",
						e.row, e.col, res_ch.last, e.last));
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int idle_count;
		idle_count = 0;
		while (idle_count < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_count = 0;
			end else begin
				idle_count++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// stimulus
	initial begin
		req_item_t it;
		req_item_t gap;
		logic [DIM_W-1:0] d_rows;
		logic [DIM_W-1:0] d_inner;
		logic [DIM_W-1:0] d_cols;
		int r;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_LOAD_A;
		req_ch.row_index = '0;
		req_ch.col_index = '0;
		req_ch.element_value = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part on a 1x1x1 product, zero dimensions read as one
		write_reg(REG_A_ROWS, 3'd0);
		write_reg(REG_INNER_SIZE, 3'd1);
		write_reg(REG_B_COLS, 3'd0);
		foreach (directed_steps[i]) begin
			send_req(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].want);
		end

		// random phases, each with its own dimensions
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin d_rows = 3'd4; d_inner = 3'd4; d_cols = 3'd4; end
				1: begin d_rows = 3'd7; d_inner = 3'd6; d_cols = 3'd5; end
				2: begin d_rows = 3'd0; d_inner = 3'd0; d_cols = 3'd0; end
				3: begin d_rows = 3'd1; d_inner = 3'd4; d_cols = 3'd1; end
				4: begin d_rows = 3'd4; d_inner = 3'd1; d_cols = 3'd4; end
				default: begin
					d_rows = DIM_W'($urandom_range(7));
					d_inner = DIM_W'($urandom_range(7));
					d_cols = DIM_W'($urandom_range(7));
				end
			endcase
			write_reg(REG_A_ROWS, d_rows);
			write_reg(REG_INNER_SIZE, d_inner);
			write_reg(REG_B_COLS, d_cols);
			calm = (p == 3);
			if (p == 4) begin
				hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				it.row = IDX_W'($urandom_range(3));
				it.col = IDX_W'($urandom_range(3));
				it.value = pick_value(p == 0);
				if (r < 12) begin
					// fill missing operands before asking for the product
					it.kind = REQ_COMPUTE;
					if (first_gap(gap)) begin
						gap.value = it.value;
						it = gap;
					end
				end else if (r < 17) begin
					it.kind = REQ_UNUSED;
				end else begin
					it.kind = $urandom_range(1) ? REQ_LOAD_B : REQ_LOAD_A;
				end
				send_req(it, 1'b0, '0);
			end
		end

		// drain and finish
		req_ch.valid = 1'b0;
		calm = 1'b0;
		while (pending_elems.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
